FILE: hw/rtl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int COUNT_BITS  = 16;

    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_CNT_W  = 4;
    localparam int CAP_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int TUSER_W    = 2;

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LIM_W  = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

    localparam logic [LIM_W-1:0] CNT_MAX = LIM_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(256);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIND_PATTERN    = 3'd0,
        CFG_FIND_COUNT      = 3'd1,
        CFG_REPLACE_PATTERN = 3'd2,
        CFG_REPLACE_COUNT   = 3'd3,
        CFG_CAPACITY        = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] find_pattern;
        logic [CFG_CNT_W-1:0]  find_count;
        logic [CFG_DATA_W-1:0] replace_pattern;
        logic [CFG_CNT_W-1:0]  replace_count;
        logic [CAP_W-1:0]      capacity;
    } cfg_t;

    // one queue entry: what a single accepted byte asks the back end to do
    typedef struct packed {
        logic                              copy_en;
        logic [BYTE_W-1:0]                 copy_byte;
        logic                              repl_en;
        logic                              end_en;
        logic [FILL_W-1:0]                 tail_cnt;
        logic [MAX_PATTERN-1:0][BYTE_W-1:0] tail;
    } cmd_t;

    typedef enum logic [1:0] {
        PH_NEW,
        PH_MAIN,
        PH_TAIL,
        PH_END
    } phase_t;

    function automatic logic [FILL_W-1:0] clamp_count(input logic [CFG_CNT_W-1:0] c);
        logic [FILL_W-1:0] r;
        if (c > CFG_CNT_W'(MAX_PATTERN)) begin
            r = FILL_W'(MAX_PATTERN);
        end else begin
            r = FILL_W'(c);
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/stream_find_replace_unit.sv
`timescale 1ns / 1ps
// output: an accepted byte's result passes through the command queue and then the registered m_tvalid/m_tdata stage
// throughput: one byte per cycle while the command queue has room; a match emits
//   min(replace_count, 8) replacement bytes, fewer once output is full; the final byte adds the
//   flushed window bytes and an end marker; a 4-entry queue lets intake and output stall apart
// reset: synchronous active-low aresetn clears queue, window fill, counters and output valid;
//   configuration returns to its reset values (capacity 256, all else zero)

module stream_find_replace_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // in_byte
    input  logic                          s_tlast,   // in_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // out_byte
    output logic [1:0]                    m_tuser,   // out_valid, truncated
    output logic                          m_tlast    // out_last
);
    import sfr_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic clear;
    logic q_ready, push, pop, head_valid;
    cmd_t push_cmd, head;

    // a new find pattern or find count abandons the string in progress
    assign clear = cfg_wr_en &&
                   (cfg_addr == CFG_FIND_PATTERN || cfg_addr == CFG_FIND_COUNT);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FIND_PATTERN:    cfg_next.find_pattern    = cfg_wdata;
                CFG_FIND_COUNT:      cfg_next.find_count      = cfg_wdata[CFG_CNT_W-1:0];
                CFG_REPLACE_PATTERN: cfg_next.replace_pattern = cfg_wdata;
                CFG_REPLACE_COUNT:   cfg_next.replace_count   = cfg_wdata[CFG_CNT_W-1:0];
                CFG_CAPACITY:        cfg_next.capacity        = cfg_wdata[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{find_pattern:    '0,
                         find_count:      '0,
                         replace_pattern: '0,
                         replace_count:   '0,
                         capacity:        CAPACITY_RESET};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sfr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .clear    (clear),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_ready  (q_ready),
        .push     (push),
        .push_cmd (push_cmd)
    );

    sfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_ready    (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sfr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .clear      (clear),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: hw/rtl/sfr_front.sv
`timescale 1ns / 1ps

module sfr_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sfr_pkg::cfg_t              cfg,
    input  logic                       clear,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_last,
    input  logic                       q_ready,
    output logic                       push,
    output sfr_pkg::cmd_t              push_cmd
);
    import sfr_pkg::*;

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_reg, win_next;
    logic [FILL_W-1:0]                  fill_reg, fill_next;
    logic [FILL_W-1:0]                  fc;
    logic                               accept;
    logic                               hit;
    cmd_t                               cmd;

    assign fc       = clamp_count(cfg.find_count);
    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        hit       = 1'b1;
        cmd       = '0;
        if (fc == '0) begin
            cmd.copy_en   = 1'b1;
            cmd.copy_byte = in_byte;
        end else begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                if (FILL_W'(k) == fill_reg) begin
                    win_next[k] = in_byte;
                end
            end
            fill_next = fill_reg + 1'b1;
            if (fill_next == fc) begin
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    if (FILL_W'(k) < fc &&
                        win_next[k] != cfg.find_pattern[BYTE_W*k +: BYTE_W]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    cmd.repl_en = 1'b1;
                    fill_next   = '0;
                end else begin
                    // oldest byte leaves the window, the rest slide down
                    cmd.copy_en   = 1'b1;
                    cmd.copy_byte = win_next[0];
                    for (int k = 0; k < MAX_PATTERN - 1; k++) begin
                        win_next[k] = win_next[k+1];
                    end
                    fill_next = fc - 1'b1;
                end
            end
        end
        if (in_last) begin
            cmd.end_en   = 1'b1;
            cmd.tail_cnt = fill_next;
            cmd.tail     = win_next;
            fill_next    = '0;
        end
    end

    assign push     = accept && (cmd.copy_en || cmd.repl_en || cmd.end_en);
    assign push_cmd = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (clear) begin
            fill_reg <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
        end
    end

endmodule

FILE: hw/rtl/sfr_queue.sv
`timescale 1ns / 1ps

module sfr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sfr_pkg::cmd_t push_cmd,
    output logic          q_ready,
    input  logic          pop,
    output logic          head_valid,
    output sfr_pkg::cmd_t head
);
    import sfr_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_pop;

    assign q_ready    = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hw/rtl/sfr_back.sv
`timescale 1ns / 1ps

module sfr_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sfr_pkg::cfg_t               cfg,
    input  logic                        clear,
    input  logic                        head_valid,
    input  sfr_pkg::cmd_t               head,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sfr_pkg::BYTE_W-1:0]  m_tdata,
    output logic [sfr_pkg::TUSER_W-1:0] m_tuser,
    output logic                        m_tlast
);
    import sfr_pkg::*;

    phase_t                             phase_reg, phase_next, eff_phase;
    logic [FILL_W-1:0]                  k_reg, k_next, k_inc;
    logic [COUNT_BITS-1:0]              wc_reg, wc_next, wc_inc;
    logic                               drop_reg, drop_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]                  m_tdata_reg;
    logic [TUSER_W-1:0]                 m_tuser_reg;
    logic                               m_tlast_reg;

    logic [CAP_W-1:0]                   cap_m1;
    logic [LIM_W-1:0]                   lim;
    logic                               full, full_after;
    logic [FILL_W-1:0]                  rc;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] repl_bytes;
    logic                               step, slot_free;
    logic                               emit, main_done;
    logic [BYTE_W-1:0]                  emit_byte;
    logic [TUSER_W-1:0]                 emit_user;
    logic                               emit_last;

    assign cap_m1 = (cfg.capacity == '0) ? '0 : cfg.capacity - 1'b1;
    assign lim    = (LIM_W'(cap_m1) > CNT_MAX) ? CNT_MAX : LIM_W'(cap_m1);
    assign rc     = clamp_count(cfg.replace_count);

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            repl_bytes[k] = cfg.replace_pattern[BYTE_W*k +: BYTE_W];
        end
    end

    assign wc_inc     = wc_reg + 1'b1;
    assign k_inc      = k_reg + 1'b1;
    assign full       = (LIM_W'(wc_reg) >= lim);
    assign full_after = (LIM_W'(wc_inc) >= lim);

    assign slot_free = !m_tvalid_reg || m_tready;
    assign step      = head_valid && slot_free;

    // a fresh head entry starts in the first phase it has work for
    always_comb begin
        if (phase_reg == PH_NEW) begin
            if (head.copy_en || head.repl_en) begin
                eff_phase = PH_MAIN;
            end else if (head.tail_cnt != '0) begin
                eff_phase = PH_TAIL;
            end else begin
                eff_phase = PH_END;
            end
        end else begin
            eff_phase = phase_reg;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        k_next     = k_reg;
        wc_next    = wc_reg;
        drop_next  = drop_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_byte  = '0;
        emit_user  = '0;
        emit_last  = 1'b0;
        main_done  = 1'b0;
        if (step) begin
            case (eff_phase)
                PH_MAIN: begin
                    if (head.copy_en) begin
                        if (full) begin
                            drop_next = 1'b1;
                        end else begin
                            emit      = 1'b1;
                            emit_byte = head.copy_byte;
                            emit_user = 2'b01;
                            wc_next   = wc_inc;
                        end
                        main_done = 1'b1;
                    end else if (k_reg == '0 && full) begin
                        drop_next = 1'b1;
                        main_done = 1'b1;
                    end else if (k_reg >= rc) begin
                        main_done = 1'b1;
                    end else begin
                        emit      = 1'b1;
                        emit_byte = repl_bytes[k_reg[IDX_W-1:0]];
                        emit_user = 2'b01;
                        wc_next   = wc_inc;
                        k_next    = k_inc;
                        main_done = (k_inc >= rc) || full_after;
                    end
                    if (main_done) begin
                        k_next = '0;
                        if (head.tail_cnt != '0) begin
                            phase_next = PH_TAIL;
                        end else if (head.end_en) begin
                            phase_next = PH_END;
                        end else begin
                            pop        = 1'b1;
                            phase_next = PH_NEW;
                        end
                    end else begin
                        phase_next = PH_MAIN;
                    end
                end
                PH_TAIL: begin
                    if (full) begin
                        drop_next = 1'b1;
                    end else begin
                        emit      = 1'b1;
                        emit_byte = head.tail[k_reg[IDX_W-1:0]];
                        emit_user = 2'b01;
                        wc_next   = wc_inc;
                    end
                    if (k_inc >= head.tail_cnt) begin
                        k_next = '0;
                        if (head.end_en) begin
                            phase_next = PH_END;
                        end else begin
                            pop        = 1'b1;
                            phase_next = PH_NEW;
                        end
                    end else begin
                        k_next     = k_inc;
                        phase_next = PH_TAIL;
                    end
                end
                PH_END: begin
                    emit       = 1'b1;
                    emit_byte  = '0;
                    emit_user  = {drop_reg, 1'b0};
                    emit_last  = 1'b1;
                    wc_next    = '0;
                    drop_next  = 1'b0;
                    k_next     = '0;
                    pop        = 1'b1;
                    phase_next = PH_NEW;
                end
                default: begin
                    phase_next = PH_NEW;
                end
            endcase
        end
        if (clear) begin
            phase_next = PH_NEW;
            k_next     = '0;
            wc_next    = '0;
            drop_next  = 1'b0;
        end
    end

    assign m_tvalid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_NEW;
            k_reg        <= '0;
            wc_reg       <= '0;
            drop_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            k_reg        <= k_next;
            wc_reg       <= wc_next;
            drop_reg     <= drop_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= emit_byte;
            m_tuser_reg <= emit_user;
            m_tlast_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: hw/rtl/sfr_checker.sv
`timescale 1ns / 1ps

module sfr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // a stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // end marker is a bare marker with zero data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == 8'd0 && !m_tuser[0])
        else $error("end marker carries a character");

    // characters never flag truncation and every non-final result is a character
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[0] && !m_tuser[1])
        else $error("bad flags on character result");

    // nothing is offered right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (.*);
